// ===== rtl/elevator_floor_scheduler_macros.svh =====
// Assertion macros used by the elevator floor scheduler datapath.
`ifndef ELEVATOR_FLOOR_SCHEDULER_MACROS_SVH
`define ELEVATOR_FLOOR_SCHEDULER_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define EFS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define EFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/efs_pkg.sv =====
// Shared types and codes for the elevator floor scheduler.
`timescale 1ns / 1ps
`default_nettype none

package efs_pkg;

   // Width of the floor fields on the ports
   localparam int FLOOR_PORT_W = 5;

   // Item kinds
   localparam logic KIND_REQUEST  = 1'b0;
   localparam logic KIND_CONTINUE = 1'b1;

   // Result actions
   localparam logic ACT_MOVE = 1'b0;
   localparam logic ACT_STOP = 1'b1;

   // Heading codes, two's complement
   localparam logic [1:0] DIR_DOWN = 2'b11;
   localparam logic [1:0] DIR_STAY = 2'b00;
   localparam logic [1:0] DIR_UP   = 2'b01;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_ARRIVE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic latch;
      logic pick;
      logic arrive;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic to_arrive;
      logic out_full;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/elevator_floor_scheduler.sv =====
// Top level of the elevator floor scheduler: controller plus datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_kind, req_requested_floor
//   rsp      out        rsp_valid/rsp_stall  rsp_action, rsp_floor_now, rsp_heading
//
// A request or continue item that yields no result returns from the pick state to idle,
// one that yields a move goes from pick to emit and one that yields a stop passes pick,
// arrive and emit; the controller steps the shared floor search in pick and arrive.
// The next item is taken in the cycle the result register is loaded.
// A stalled result holds the controller in its emit state until the register frees.
// Synchronous reset restores the start floor and clears the pending mask at once.
`timescale 1ns / 1ps
`default_nettype none

module elevator_floor_scheduler
   import efs_pkg::*;
#(
   parameter int FLOORS      = 16,
   parameter int START_LEVEL = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_kind,
   input  wire logic [FLOOR_PORT_W-1:0] req_requested_floor,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_action,
   output logic [FLOOR_PORT_W-1:0]      rsp_floor_now,
   output logic signed [1:0]            rsp_heading
);

   cmd_type    cmd;
   status_type status;

   efs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   efs_datapath #(
      .FLOORS      (FLOORS),
      .START_LEVEL (START_LEVEL)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_kind),
      .req_requested_floor (req_requested_floor),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_floor_now       (rsp_floor_now),
      .rsp_heading         (rsp_heading)
   );

endmodule

`default_nettype wire

// ===== rtl/efs_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module efs_ctrl
   import efs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold the current state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            if (status.skip) begin
               state_in = ST_IDLE;
            end else if (status.to_arrive) begin
               state_in = ST_ARRIVE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_ARRIVE: begin
            cmd.arrive = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            // Load the result and take the next item in the same cycle
            if (!status.out_full) begin
               cmd.emit  = 1'b1;
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.latch = 1'b1;
                  state_in  = ST_PICK;
               end else begin
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/efs_datapath.sv =====
// Datapath: scheduler state, nearest pending floor search and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "elevator_floor_scheduler_macros.svh"

module efs_datapath
   import efs_pkg::*;
#(
   parameter int FLOORS      = 16,
   parameter int START_LEVEL = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output status_type                   status,
   input  wire logic                    req_kind,
   input  wire logic [FLOOR_PORT_W-1:0] req_requested_floor,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_action,
   output logic [FLOOR_PORT_W-1:0]      rsp_floor_now,
   output logic signed [1:0]            rsp_heading
);

   localparam int MAXF = (FLOORS > START_LEVEL) ? FLOORS : START_LEVEL;
   localparam int FW   = $clog2(MAXF + 1);
   localparam int OW   = (FW > FLOOR_PORT_W) ? FW : FLOOR_PORT_W;

   // Lowest set bit of a mask as a floor number, zero when empty
   function automatic logic [FW-1:0] lowest_floor(input logic [FLOORS-1:0] x);
      logic [FLOORS-1:0] oh;
      logic [FW-1:0]     idx;
      oh  = x & (~x + 1'b1);
      idx = '0;
      for (int i = 0; i < FLOORS; i++) begin
         if (oh[i]) idx = idx | FW'(i + 1);
      end
      return idx;
   endfunction

   // Highest set bit of a mask as a floor number, zero when empty
   function automatic logic [FW-1:0] highest_floor(input logic [FLOORS-1:0] x);
      logic [FLOORS-1:0] rev;
      logic [FLOORS-1:0] oh;
      logic [FW-1:0]     idx;
      for (int i = 0; i < FLOORS; i++) begin
         rev[i] = x[FLOORS-1-i];
      end
      oh  = rev & (~rev + 1'b1);
      idx = '0;
      for (int j = 0; j < FLOORS; j++) begin
         if (oh[j]) idx = idx | FW'(FLOORS - j);
      end
      return idx;
   endfunction

   // Heading from a floor toward a target
   function automatic logic [1:0] aim(input logic [FW-1:0] tgt, input logic [FW-1:0] cur);
      logic [1:0] d;
      if (tgt < cur) begin
         d = DIR_DOWN;
      end else if (tgt > cur) begin
         d = DIR_UP;
      end else begin
         d = DIR_STAY;
      end
      return d;
   endfunction

   // Scheduler state
   logic [FW-1:0]     cur_ff,    cur_in;
   logic [FW-1:0]     tgt_ff,    tgt_in;
   logic              busy_ff,   busy_in;
   logic [1:0]        travel_ff, travel_in;
   logic [FLOORS-1:0] mask_ff,   mask_in;

   // Latched item and pending action
   logic                    kind_ff;
   logic [FLOOR_PORT_W-1:0] floor_ff;
   logic                    act_ff, act_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_action_ff;
   logic [FLOOR_PORT_W-1:0] rsp_floor_ff;
   logic [1:0]              rsp_heading_ff;

   // Search and step signals
   logic [FLOORS-1:0] fbit, tbit, dn_sel, up_sel, srch_mask;
   logic              in_range, req_ok, found;
   logic [FW-1:0]     dn_f, up_f, nf, tgt0, c2;
   logic [OW-1:0]     freq_wide, cur_wide;
   logic [1:0]        dir0, dir1, dir2;

   // One-hot requested/target floors; floors at or below and at or above cur
   always_comb begin
      for (int i = 0; i < FLOORS; i++) begin
         fbit[i]   = (int'(floor_ff) == i + 1);
         tbit[i]   = (int'(tgt_ff) == i + 1);
         dn_sel[i] = (int'(cur_ff) > i);
         up_sel[i] = (int'(cur_ff) <= i + 1);
      end
   end

   // Pick the mask the search sees in this step
   always_comb begin
      if (cmd.arrive) begin
         srch_mask = mask_ff & ~tbit;
      end else if (kind_ff == KIND_REQUEST) begin
         srch_mask = mask_ff | fbit;
      end else begin
         srch_mask = mask_ff;
      end
   end

   // Search along the heading first (down when stopped), then the other way
   always_comb begin
      in_range = (cur_ff != '0) && (int'(cur_ff) <= FLOORS);
      dn_f     = highest_floor(srch_mask & dn_sel);
      up_f     = lowest_floor(srch_mask & up_sel);
      if (!in_range) begin
         nf = '0;
      end else if (travel_ff == DIR_UP) begin
         nf = (up_f != '0) ? up_f : dn_f;
      end else begin
         nf = (dn_f != '0) ? dn_f : up_f;
      end
   end

   // Evaluate both item kinds against the current state
   always_comb begin
      freq_wide = OW'(floor_ff);
      cur_wide  = OW'(cur_ff);
      req_ok    = (|fbit) && !(|(mask_ff & fbit));
      tgt0      = (nf != '0) ? nf : freq_wide[FW-1:0];
      dir0      = aim(tgt0, cur_ff);
      found     = (nf != '0);
      dir1      = aim(nf, cur_ff);
      c2        = (dir1 == DIR_UP) ? cur_ff + 1'b1 : cur_ff - 1'b1;
      dir2      = aim(nf, c2);
   end

   // Report to the controller
   always_comb begin
      if (kind_ff == KIND_REQUEST) begin
         status.skip      = !req_ok;
         status.to_arrive = (dir0 == DIR_STAY);
      end else begin
         status.skip      = !found;
         status.to_arrive = (dir1 == DIR_STAY) || (dir2 == DIR_STAY);
      end
      status.out_full = rsp_valid_ff && rsp_stall;
   end

   // Next values of the scheduler state
   always_comb begin
      cur_in    = cur_ff;
      tgt_in    = tgt_ff;
      busy_in   = busy_ff;
      travel_in = travel_ff;
      mask_in   = mask_ff;
      act_in    = act_ff;
      if (cmd.pick) begin
         act_in = ACT_MOVE;
         if (kind_ff == KIND_REQUEST) begin
            if (req_ok) begin
               busy_in   = 1'b1;
               mask_in   = mask_ff | fbit;
               tgt_in    = tgt0;
               travel_in = dir0;
            end
         end else begin
            busy_in = 1'b1;
            if (found) begin
               tgt_in = nf;
               if (dir1 == DIR_STAY) begin
                  travel_in = DIR_STAY;
               end else begin
                  cur_in    = c2;
                  travel_in = dir2;
               end
            end
         end
      end else if (cmd.arrive) begin
         // Free the cabin, clear the floor reached and re-pick
         busy_in = 1'b0;
         mask_in = mask_ff & ~tbit;
         act_in  = ACT_STOP;
         if (nf != '0) begin
            tgt_in = nf;
         end
      end
   end

   // Advance or drop the result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= FW'(START_LEVEL);
         tgt_ff       <= '0;
         busy_ff      <= 1'b0;
         travel_ff    <= DIR_STAY;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         busy_ff      <= busy_in;
         travel_ff    <= travel_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff <= act_in;
      if (cmd.latch) begin
         kind_ff  <= req_kind;
         floor_ff <= req_requested_floor;
      end
      if (cmd.emit) begin
         rsp_action_ff  <= act_ff;
         rsp_floor_ff   <= cur_wide[FLOOR_PORT_W-1:0];
         rsp_heading_ff <= travel_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = rsp_action_ff;
   assign rsp_floor_now = rsp_floor_ff;
   assign rsp_heading   = rsp_heading_ff;

   `EFS_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, !(rsp_valid_ff && rsp_stall), "result overwritten while stalled")
   `EFS_ASSERT_SAME(a_arrive_busy, clock, reset, cmd.arrive, busy_ff, "arrival while cabin free")
   `EFS_ASSERT_SAME(a_arrive_stay, clock, reset, cmd.arrive, travel_ff == DIR_STAY, "arrival with cabin heading away")
   `EFS_ASSERT_NEXT(a_arrive_free, clock, reset, cmd.arrive, !busy_ff && (act_ff == ACT_STOP), "arrival did not free cabin")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the elevator floor scheduler.
`timescale 1ns / 1ps

module testbench;
   import efs_pkg::*;

   localparam int NUM_FLOORS   = 16;
   localparam int HOME_FLOOR   = 1;
   localparam int QUIET_TAIL   = 150;
   localparam int RANDOM_ITEMS = 1200;
   localparam int IDLE_LIMIT   = 1000;

   typedef struct packed {
      logic                    kind;
      logic [FLOOR_PORT_W-1:0] floor;
      logic                    drain_first;
   } cabin_call_type;

   typedef struct packed {
      logic                    action;
      logic [FLOOR_PORT_W-1:0] floor_now;
      logic signed [1:0]       heading;
   } cabin_report_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_kind = KIND_REQUEST;
   logic [FLOOR_PORT_W-1:0] req_requested_floor = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_action;
   logic [FLOOR_PORT_W-1:0] rsp_floor_now;
   logic signed [1:0]       rsp_heading;

   cabin_call_type   pending_calls[$];
   cabin_report_type expected_reports[$];
   cabin_call_type   call_on_bus;

   // Scheduler state mirrored by the predictor
   int                  cab_floor;
   int                  goal_floor;
   bit                  cab_busy;
   int                  cab_dir;
   logic [NUM_FLOORS:1] waiting_floors;

   int fail_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int n_requests = 0;
   int n_continues = 0;
   int n_stops = 0;
   int n_moves = 0;

   elevator_floor_scheduler #(
      .FLOORS      (NUM_FLOORS),
      .START_LEVEL (HOME_FLOOR)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_requested_floor (req_requested_floor),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_floor_now       (rsp_floor_now),
      .rsp_heading         (rsp_heading)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Nearest waiting floor: along the heading first (down when stopped), then back
   function automatic int nearest_waiting();
      int step;
      int f;
      int pass;
      step = (cab_dir != 0) ? cab_dir : -1;
      for (pass = 0; pass < 2; pass++) begin
         f = cab_floor;
         while (f >= 1 && f <= NUM_FLOORS) begin
            if (waiting_floors[f]) return f;
            f += step;
         end
         step = -step;
      end
      return 0;
   endfunction

   function automatic void aim_cabin();
      if (goal_floor < cab_floor) cab_dir = -1;
      else if (goal_floor > cab_floor) cab_dir = 1;
      else cab_dir = 0;
   endfunction

   function automatic cabin_report_type make_report(logic action);
      cabin_report_type rep;
      rep.action    = action;
      rep.floor_now = cab_floor[FLOOR_PORT_W-1:0];
      rep.heading   = (cab_dir < 0) ? DIR_DOWN : (cab_dir > 0) ? DIR_UP : DIR_STAY;
      return rep;
   endfunction

   // Cabin at its goal while busy: free it, clear the floor, pick the next goal
   function automatic bit arrive_cabin(output cabin_report_type rep);
      int nf;
      rep = '0;
      if (!cab_busy) return 0;
      cab_busy = 0;
      if (goal_floor >= 1 && goal_floor <= NUM_FLOORS) waiting_floors[goal_floor] = 1'b0;
      nf = nearest_waiting();
      if (nf != 0) goal_floor = nf;
      rep = make_report(ACT_STOP);
      return 1;
   endfunction

   // Advance the mirrored state by one item; return 1 when a report is due
   function automatic bit schedule_cabin(input cabin_call_type c,
                                         output cabin_report_type rep);
      int f;
      int nf;
      rep = '0;
      if (c.kind == KIND_REQUEST) begin
         f = c.floor;
         if (f < 1 || f > NUM_FLOORS) return 0;
         if (waiting_floors[f]) return 0;
         cab_busy = 1;
         waiting_floors[f] = 1'b1;
         nf = nearest_waiting();
         goal_floor = (nf != 0) ? nf : f;
         aim_cabin();
         if (cab_dir == 0) return arrive_cabin(rep);
         rep = make_report(ACT_MOVE);
         return 1;
      end
      cab_busy = 1;
      nf = nearest_waiting();
      if (nf == 0) return 0;
      goal_floor = nf;
      aim_cabin();
      if (cab_dir == 0) return arrive_cabin(rep);
      cab_floor += cab_dir;
      aim_cabin();
      if (cab_dir == 0) return arrive_cabin(rep);
      rep = make_report(ACT_MOVE);
      return 1;
   endfunction

   task automatic add_call(input logic kind, input int floor, input logic drain_first);
      cabin_call_type c;
      c.kind        = kind;
      c.floor       = floor[FLOOR_PORT_W-1:0];
      c.drain_first = drain_first;
      pending_calls.push_back(c);
   endtask

   // Feed items from the queue, with random gaps until the quiet tail
   always @(posedge clock) begin : drive_calls
      cabin_report_type rep;
      bit               load;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (call_on_bus.kind == KIND_REQUEST) n_requests++;
            else n_continues++;
            if (schedule_cabin(call_on_bus, rep)) expected_reports.push_back(rep);
         end
         if (!(req_valid && req_stall)) begin
            load = 0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_calls.size() > 0 &&
                         !(pending_calls[0].drain_first && expected_reports.size() != 0)) begin
               if (pending_calls.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                  gap_left = $urandom_range(0, 14);
               else
                  load = 1;
            end
            if (load) begin
               call_on_bus = pending_calls.pop_front();
               req_valid           <= 1'b1;
               req_kind            <= call_on_bus.kind;
               req_requested_floor <= call_on_bus.floor;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Stall the result side in random bursts until the quiet tail
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (pending_calls.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin : check_reports
      cabin_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected result: action %0d floor_now %0d heading %0d",
                   rsp_action, rsp_floor_now, rsp_heading);
            fail_count++;
         end else begin
            want = expected_reports.pop_front();
            if (want.action === ACT_STOP) n_stops++;
            else n_moves++;
            if (rsp_action !== want.action) begin
               $error("action: expected %0d, got %0d", want.action, rsp_action);
               fail_count++;
            end
            if (rsp_floor_now !== want.floor_now) begin
               $error("floor_now: expected %0d, got %0d", want.floor_now, rsp_floor_now);
               fail_count++;
            end
            if (rsp_heading !== want.heading) begin
               $error("heading: expected %0d, got %0d", want.heading, rsp_heading);
               fail_count++;
            end
         end
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int counted;
      int n_req;
      int n_cont;
      int f;
      int i;
      bit drain;

      cab_floor      = HOME_FLOOR;
      goal_floor     = 0;
      cab_busy       = 0;
      cab_dir        = 0;
      waiting_floors = '0;

      // Directed: idle continue, out-of-range floors, stop at the cabin floor,
      // duplicate request, search along and against the heading
      add_call(KIND_CONTINUE, 0, 1'b0);
      add_call(KIND_REQUEST, 0, 1'b0);
      add_call(KIND_REQUEST, 17, 1'b0);
      add_call(KIND_REQUEST, 31, 1'b0);
      add_call(KIND_REQUEST, 1, 1'b0);
      add_call(KIND_REQUEST, 16, 1'b0);
      add_call(KIND_REQUEST, 16, 1'b0);
      add_call(KIND_REQUEST, 8, 1'b0);
      for (i = 0; i < 3; i++) add_call(KIND_CONTINUE, 0, 1'b0);
      add_call(KIND_REQUEST, 2, 1'b0);
      for (i = 0; i < 4; i++) add_call(KIND_CONTINUE, 0, 1'b0);
      for (i = 0; i < 6; i++) add_call(KIND_CONTINUE, 31, 1'b0);

      // Random trips: a few requests, then a run of continues; some noise
      counted = 0;
      drain   = 1'b1;
      while (counted < RANDOM_ITEMS) begin
         n_req = $urandom_range(1, 3);
         for (i = 0; i < n_req; i++) begin
            if ($urandom_range(0, 9) == 0) f = $urandom_range(0, 31);
            else f = $urandom_range(1, NUM_FLOORS);
            if ($urandom_range(0, 19) == 0) begin
               add_call(KIND_CONTINUE, f, drain);
               counted++;
            end else begin
               add_call(KIND_REQUEST, f, drain);
               if (f >= 1 && f <= NUM_FLOORS) counted++;
            end
            drain = 1'b0;
         end
         n_cont = $urandom_range(1, 20);
         for (i = 0; i < n_cont; i++) add_call(KIND_CONTINUE, $urandom_range(0, 31), 1'b0);
         counted += n_cont;
         drain = ($urandom_range(0, 39) == 0);
      end

      @(posedge clock);
      while (pending_calls.size() != 0 || req_valid) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Drove %0d floor requests and %0d continue items", n_requests, n_continues);
      $display("Checked %0d stop and %0d move results", n_stops, n_moves);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
